### hdl/ssfm_pkg.sv
// ----------------------------------------------------------------------------
// Substring first-match package
// Shared types and register indexes for the substring search block.
// ----------------------------------------------------------------------------
package ssfm_pkg;

    // Needle length register width and byte geometry.
    localparam int LEN_W     = 5;
    localparam int BYTE_W    = 8;
    localparam int NEEDLE_W  = 64;
    localparam int INDEX_W   = 16;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NEEDLE_LOW    = 2'd0,
        REG_NEEDLE_HIGH   = 2'd1,
        REG_NEEDLE_LENGTH = 2'd2
    } cfg_reg_t;

    // Sixteen needle bytes, byte 0 in the lowest bits.
    typedef logic [15:0][BYTE_W-1:0] needle_t;

    // Request handed from the front stage to the window cells.
    typedef struct packed {
        logic              shift;
        logic [BYTE_W-1:0] data;
    } win_in_t;

    // Front stage to compare stage record.
    typedef struct packed {
        logic               chk;        // window must be compared
        logic               last;       // end of haystack
        logic               ovf;        // haystack was too long
        logic               empty;      // needle is empty
        logic [INDEX_W-1:0] cand_idx;   // candidate match start
        logic [INDEX_W-1:0] empty_idx;  // result index for an empty needle
    } stage_t;

endpackage

### hdl/ssfm_cell.sv
// ----------------------------------------------------------------------------
// Window cell
// Holds one recent haystack byte, passes it to the next cell on a shift and
// compares it against the needle byte that lines up with its place.
// ----------------------------------------------------------------------------
module ssfm_cell #(
    parameter int IDX = 0
) (
    input  logic                                  aclk,
    input  logic                                  shift_en,
    input  logic [ssfm_pkg::BYTE_W-1:0]           byte_in,
    input  ssfm_pkg::needle_t                     needle,
    input  logic [ssfm_pkg::LEN_W-1:0]            used_len,
    output logic [ssfm_pkg::BYTE_W-1:0]           byte_out,
    output logic                                  eq
);
    import ssfm_pkg::*;

    logic [BYTE_W-1:0] byte_reg;
    logic [3:0]        sel;
    logic              active;

    // Shift register stage of the window.
    always_ff @(posedge aclk) begin
        if (shift_en) begin
            byte_reg <= byte_in;
        end
    end

    // The cell that holds the byte IDX places before the newest lines up with
    // needle byte used_len - 1 - IDX.
    assign active   = (LEN_W'(IDX) < used_len);
    assign sel      = 4'(used_len - LEN_W'(1) - LEN_W'(IDX));
    assign eq       = !active || (byte_reg == needle[sel]);
    assign byte_out = byte_reg;

endmodule

### hdl/ssfm_window.sv
// ----------------------------------------------------------------------------
// Window of recent bytes
// A chain of cells that shifts in one haystack byte per request and reports
// whether the newest bytes equal the needle.
// ----------------------------------------------------------------------------
module ssfm_window #(
    parameter int NEEDLE_MAX = 16
) (
    input  logic                          aclk,
    input  ssfm_pkg::win_in_t             win_in,
    input  ssfm_pkg::needle_t             needle,
    input  logic [ssfm_pkg::LEN_W-1:0]    used_len,
    output logic                          match
);
    import ssfm_pkg::*;

    logic [NEEDLE_MAX:0][BYTE_W-1:0] link;
    logic [NEEDLE_MAX-1:0]           eq;

    assign link[0] = win_in.data;

    // Cell 0 holds the newest byte; each shift moves every byte one cell on.
    for (genvar g = 0; g < NEEDLE_MAX; g++) begin : g_cell
        ssfm_cell #(
            .IDX (g)
        ) u_cell (
            .aclk     (aclk),
            .shift_en (win_in.shift),
            .byte_in  (link[g]),
            .needle   (needle),
            .used_len (used_len),
            .byte_out (link[g+1]),
            .eq       (eq[g])
        );
    end

    // The last cell's output has no neighbor; it only closes the chain.
    logic unused_tail;
    assign unused_tail = ^link[NEEDLE_MAX];

    assign match = &eq;

endmodule

### hdl/substring_first_match_unit.sv
// ----------------------------------------------------------------------------
// Substring first-match unit
// Finds the first position at or after a start offset where the configured
// needle occurs in a haystack streamed one byte per request.
// ----------------------------------------------------------------------------
//  Channel   Direction  Contents
//  s_*       in         tdata: text_byte, start_offset; tuser: byte_present;
//                       tlast: last_byte
//  m_*       out        tdata: match_index; tuser: found, overflow
//  cfg_*     in         needle_bytes_low, needle_bytes_high, needle_length
//
//  One request is accepted every cycle unless the input stalls. The window
//  shifts on the accept edge, the compare stage checks it, and the output
//  register takes the result of a last request. Reset is synchronous and
//  clears the position, start offset, hit and handshake state. Input stalls
//  only when a finished result waits in the output register and the next
//  end-of-haystack result reaches the compare stage.
// ----------------------------------------------------------------------------
module substring_first_match_unit #(
    parameter int              NEEDLE_MAX = 16,
    parameter longint unsigned TEXT_MAX   = 65536
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Configuration write port
    input  logic                                cfg_wr_en,
    input  logic [ssfm_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  logic [ssfm_pkg::NEEDLE_W-1:0]       cfg_wr_data,
    // Input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [23:0]                         s_tdata,   // text_byte, start_offset
    input  logic [0:0]                          s_tuser,   // byte_present
    input  logic                                s_tlast,
    // Result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [15:0]                         m_tdata,   // match_index
    output logic [1:0]                          m_tuser    // found, overflow
);
    import ssfm_pkg::*;

    localparam int POS_W = $clog2(TEXT_MAX + 1);
    localparam int CW    = ((POS_W > INDEX_W) ? POS_W : INDEX_W) + 1;

    // Configuration registers.
    logic [NEEDLE_W-1:0] needle_low_reg;
    logic [NEEDLE_W-1:0] needle_high_reg;
    logic [LEN_W-1:0]    needle_len_reg;
    needle_t             needle;
    logic [LEN_W-1:0]    used_len;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            needle_low_reg  <= '0;
            needle_high_reg <= '0;
            needle_len_reg  <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_NEEDLE_LOW:    needle_low_reg  <= cfg_wr_data;
                REG_NEEDLE_HIGH:   needle_high_reg <= cfg_wr_data;
                REG_NEEDLE_LENGTH: needle_len_reg  <= cfg_wr_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    assign needle   = needle_t'({needle_high_reg, needle_low_reg});
    assign used_len = (needle_len_reg > LEN_W'(NEEDLE_MAX)) ? LEN_W'(NEEDLE_MAX)
                                                            : needle_len_reg;

    // Front stage state.
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [INDEX_W-1:0] start_reg, start_next;
    logic               too_long_reg, too_long_next;

    // Compare stage state.
    logic               b_valid_reg;
    stage_t             b_reg, b_next;
    logic               hit_seen_reg;
    logic [INDEX_W-1:0] hit_index_reg;

    // Output register.
    logic               out_valid_reg;
    logic               out_found_reg;
    logic               out_ovf_reg;
    logic [INDEX_W-1:0] out_index_reg;

    logic               pipe_en;
    logic               in_acc;
    logic               take;
    logic [BYTE_W-1:0]  text_byte;
    logic [INDEX_W-1:0] start_offset;
    logic [CW-1:0]      pos1_ext;
    logic [CW-1:0]      cand_ext;
    logic [CW-1:0]      start_ext;
    logic [CW-1:0]      posn_ext;
    logic               win_match;
    logic               hit_now;
    win_in_t            win_in;

    // The pipeline holds only when a finished result cannot leave.
    assign pipe_en  = !(b_valid_reg && b_reg.last && out_valid_reg && !m_tready);
    assign s_tready = pipe_en;
    assign in_acc   = s_tvalid && pipe_en;

    assign text_byte    = s_tdata[7:0];
    assign start_offset = s_tdata[23:8];

    // Front stage: latch the start, count the byte, decide whether to compare.
    always_comb begin
        start_next    = (pos_reg == '0) ? start_offset : start_reg;
        take          = s_tuser[0] && (pos_reg != POS_W'(TEXT_MAX));
        too_long_next = too_long_reg || (s_tuser[0] && !take);
        pos_next      = take ? (pos_reg + POS_W'(1)) : pos_reg;
        pos1_ext      = CW'(pos_reg) + CW'(1);
        cand_ext      = pos1_ext - CW'(used_len);
        start_ext     = CW'(start_next);
        posn_ext      = CW'(pos_next);

        b_next.chk       = take && (used_len != '0) && (pos1_ext >= CW'(used_len))
                           && (cand_ext >= start_ext);
        b_next.last      = s_tlast;
        b_next.ovf       = too_long_next;
        b_next.empty     = (used_len == '0);
        b_next.cand_idx  = cand_ext[INDEX_W-1:0];
        b_next.empty_idx = (start_ext < posn_ext) ? start_ext[INDEX_W-1:0]
                                                  : posn_ext[INDEX_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg      <= '0;
            start_reg    <= '0;
            too_long_reg <= 1'b0;
        end else if (in_acc) begin
            if (s_tlast) begin
                pos_reg      <= '0;
                start_reg    <= '0;
                too_long_reg <= 1'b0;
            end else begin
                pos_reg      <= pos_next;
                start_reg    <= start_next;
                too_long_reg <= too_long_next;
            end
        end
    end

    // Window of recent bytes.
    assign win_in.shift = in_acc && take;
    assign win_in.data  = text_byte;

    ssfm_window #(
        .NEEDLE_MAX (NEEDLE_MAX)
    ) u_window (
        .aclk     (aclk),
        .win_in   (win_in),
        .needle   (needle),
        .used_len (used_len),
        .match    (win_match)
    );

    // Stage register between the front stage and the compare stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            b_valid_reg <= in_acc && (b_next.chk || b_next.last);
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en && in_acc) begin
            b_reg <= b_next;
        end
    end

    // Compare stage: the first hit wins and is kept until the end.
    assign hit_now = b_reg.chk && !hit_seen_reg && win_match;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_seen_reg <= 1'b0;
        end else if (pipe_en && b_valid_reg) begin
            if (b_reg.last) begin
                hit_seen_reg <= 1'b0;
            end else if (hit_now) begin
                hit_seen_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en && b_valid_reg && hit_now) begin
            hit_index_reg <= b_reg.cand_idx;
        end
    end

    // Output register, loaded with the result of an end-of-haystack request.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (pipe_en && b_valid_reg && b_reg.last) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en && b_valid_reg && b_reg.last) begin
            if (b_reg.ovf) begin
                out_found_reg <= 1'b0;
                out_ovf_reg   <= 1'b1;
                out_index_reg <= '0;
            end else if (b_reg.empty) begin
                out_found_reg <= 1'b1;
                out_ovf_reg   <= 1'b0;
                out_index_reg <= b_reg.empty_idx;
            end else if (hit_seen_reg) begin
                out_found_reg <= 1'b1;
                out_ovf_reg   <= 1'b0;
                out_index_reg <= hit_index_reg;
            end else if (hit_now) begin
                out_found_reg <= 1'b1;
                out_ovf_reg   <= 1'b0;
                out_index_reg <= b_reg.cand_idx;
            end else begin
                out_found_reg <= 1'b0;
                out_ovf_reg   <= 1'b0;
                out_index_reg <= '0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_index_reg;
    assign m_tuser  = {out_ovf_reg, out_found_reg};

endmodule

### hdl/ssfm_checker.sv
// ----------------------------------------------------------------------------
// Substring first-match port checker
// Watches the result port of the unit over time and flags bad results.
// ----------------------------------------------------------------------------
module ssfm_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,
    input  logic [1:0]  m_tuser
);

    // A stalled result keeps its value.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // An overflowed haystack never reports a match.
    a_ovf_no_found: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> !m_tuser[0])
        else $error("overflow reported together with found");

    // A miss carries a zero index.
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata == 16'd0)
        else $error("nonzero index without a match");

    // No result is offered right after reset.
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result offered after reset");

endmodule

bind substring_first_match_unit ssfm_checker u_ssfm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

### verif/substring_first_match_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Substring first-match unit testbench
// Streams haystacks into the unit and checks every reported search result
// against a predictor that tracks the byte window, position, start offset and
// first hit. It covers directed corner cases and randomized needles and
// haystacks with random idling on both streams.
// ----------------------------------------------------------------------------
module substring_first_match_unit_tb;
    import ssfm_pkg::*;

    localparam int          TEXT_LIMIT      = 65536;
    localparam int          NEEDLE_SLOTS    = 16;
    localparam int          RANDOM_REQUESTS = 650;
    localparam longint      CYCLE_LIMIT     = 1000000;

    // One search result as carried on the result stream.
    typedef struct packed {
        logic               found;
        logic [INDEX_W-1:0] index;
        logic               overflow;
    } search_result_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_addr;
    logic [NEEDLE_W-1:0]  cfg_wr_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [23:0]          s_tdata;   // text_byte, start_offset
    logic [0:0]           s_tuser;   // byte_present
    logic                 s_tlast;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [15:0]          m_tdata;   // match_index
    logic [1:0]           m_tuser;   // found, overflow

    // Predictor copy of the needle registers and the per-haystack search state.
    logic [NEEDLE_W-1:0] ndl_low;
    logic [NEEDLE_W-1:0] ndl_high;
    logic [LEN_W-1:0]    ndl_len;
    logic [BYTE_W-1:0]   win_bytes [NEEDLE_SLOTS];
    int unsigned         text_pos;
    logic [INDEX_W-1:0]  search_start;
    logic [INDEX_W-1:0]  hit_at;
    logic                hit_found;
    logic                text_overrun;

    search_result_t      pending_results[$];
    logic [BYTE_W-1:0]   haystack_text[$];

    int     error_count   = 0;
    int     result_count  = 0;
    int     request_count = 0;
    int     config_count  = 0;
    longint cycle_count   = 0;
    bit     idling        = 1'b1;

    substring_first_match_unit i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    // Clock generation.
    initial aclk = 1'b0;
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Watchdog on the total run length.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("substring_first_match_unit verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Search predictor
    // ------------------------------------------------------------------------

    // Lengths above the window size are treated as a full window.
    function automatic int unsigned active_length();
        return (ndl_len > NEEDLE_SLOTS) ? NEEDLE_SLOTS : int'(ndl_len);
    endfunction

    function automatic logic [BYTE_W-1:0] needle_at(int k);
        needle_t all;
        all = {ndl_high, ndl_low};
        return all[k];
    endfunction

    // The newest byte sits in slot 0, so needle byte k is n-1-k slots back.
    function automatic bit window_holds_needle(int unsigned n);
        for (int k = 0; k < n; k++) begin
            if (win_bytes[n - 1 - k] != needle_at(k))
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void clear_search();
        foreach (win_bytes[i])
            win_bytes[i] = '0;
        text_pos     = 0;
        search_start = '0;
        hit_found    = 1'b0;
        hit_at       = '0;
        text_overrun = 1'b0;
    endfunction

    // Applies one accepted request and queues the result it produces, if any.
    function automatic void track_search(logic [7:0] b, logic present, logic last,
                                         logic [15:0] start);
        int unsigned    n;
        search_result_t res;
        // The start offset follows the stream until the first byte is taken.
        if (text_pos == 0 && !text_overrun)
            search_start = start;
        if (present) begin
            if (text_pos >= TEXT_LIMIT) begin
                text_overrun = 1'b1;
            end else begin
                for (int i = NEEDLE_SLOTS - 1; i > 0; i--)
                    win_bytes[i] = win_bytes[i - 1];
                win_bytes[0] = b;
                text_pos++;
                n = active_length();
                if (n != 0 && !hit_found && text_pos >= n) begin
                    if (text_pos - n >= search_start && window_holds_needle(n)) begin
                        hit_found = 1'b1;
                        hit_at    = INDEX_W'(text_pos - n);
                    end
                end
            end
        end
        if (last) begin
            res = '0;
            if (text_overrun) begin
                res.overflow = 1'b1;
            end else if (active_length() == 0) begin
                // An empty needle matches at the start offset, clipped to the end.
                res.found = 1'b1;
                res.index = (search_start < text_pos) ? search_start : INDEX_W'(text_pos);
            end else if (hit_found) begin
                res.found = 1'b1;
                res.index = hit_at;
            end
            pending_results.push_back(res);
            clear_search();
        end
    endfunction

    // ------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------

    task automatic log_mismatch(string what, int unsigned got, int unsigned want);
        error_count++;
        $display("MISMATCH result %0d: %s got %0d expected %0d",
                 result_count, what, got, want);
    endtask

    task automatic check_result();
        search_result_t want;
        result_count++;
        if (pending_results.size() == 0) begin
            log_mismatch("result with no search pending, match_index", m_tdata, 0);
        end else begin
            want = pending_results.pop_front();
            if (m_tuser[0] !== want.found)
                log_mismatch("found", m_tuser[0], want.found);
            if (m_tdata !== want.index)
                log_mismatch("match_index", m_tdata, want.index);
            if (m_tuser[1] !== want.overflow)
                log_mismatch("overflow", m_tuser[1], want.overflow);
        end
    endtask

    // Result sink: random back-pressure before every result while idling is set.
    initial begin : result_sink
        int unsigned stall;
        m_tready <= 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            stall = idling ? $urandom_range(0, 7) : 0;
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            check_result();
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Sends one request, after a random gap while idling is set, and feeds the predictor on accept.
    task automatic send_request(logic [7:0] b, logic present, logic last,
                                logic [15:0] start);
        int unsigned gap;
        gap = idling ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {start, b};
        s_tuser  <= present;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        request_count++;
        track_search(b, present, last, start);
    endtask

    // Sends haystack_text as one haystack; an empty text becomes a marker request.
    task automatic send_haystack(logic [15:0] start, bit noisy, bit marker_last);
        if (haystack_text.size() == 0) begin
            send_request(8'($urandom), 1'b0, 1'b1, start);
        end else begin
            foreach (haystack_text[i]) begin
                if (noisy && $urandom_range(0, 5) == 0)
                    send_request(8'($urandom), 1'b0, 1'b0, 16'($urandom));
                send_request(haystack_text[i], 1'b1,
                             (i == haystack_text.size() - 1) && !marker_last, start);
            end
            if (marker_last)
                send_request(8'($urandom), 1'b0, 1'b1, 16'($urandom));
        end
    endtask

    function automatic void add_bytes(logic [31:0] word, int count);
        for (int k = 0; k < count; k++)
            haystack_text.push_back(word[8*k +: 8]);
    endfunction

    // Stops the input stream and waits until every result has come back.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [NEEDLE_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= value;
        @(posedge aclk);
        case (idx)
            REG_NEEDLE_LOW:    ndl_low  = value;
            REG_NEEDLE_HIGH:   ndl_high = value;
            REG_NEEDLE_LENGTH: ndl_len  = value[LEN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_needle(logic [63:0] low, logic [63:0] high, logic [LEN_W-1:0] len);
        wait_idle();
        write_reg(REG_NEEDLE_LOW, low);
        write_reg(REG_NEEDLE_HIGH, high);
        write_reg(REG_NEEDLE_LENGTH, NEEDLE_W'(len));
        cfg_wr_en <= 1'b0;
        config_count++;
    endtask

    function automatic logic [63:0] pick_word();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [LEN_W-1:0] pick_length();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return LEN_W'(NEEDLE_SLOTS);
            2: return LEN_W'($urandom_range(17, 31));
            default: return LEN_W'($urandom_range(1, 6));
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // The needle is empty after reset: results give the clipped start offset.
    task automatic test_reset_state();
        haystack_text.delete();
        send_haystack(16'd5, 1'b0, 1'b0);
        add_bytes(32'h0000_FF00, 2);
        send_haystack(16'hFFFF, 1'b0, 1'b0);
    endtask

    task automatic test_special_cases();
        int k;
        // Needle 00 FF; bare requests before and inside the haystack.
        set_needle(64'h0000_0000_0000_FF00, '0, 5'd2);
        send_request(8'h5A, 1'b0, 1'b0, 16'd1);
        send_request(8'hFF, 1'b1, 1'b0, 16'd1);
        send_request(8'h00, 1'b1, 1'b0, 16'd1);
        send_request(8'hA5, 1'b0, 1'b0, 16'hFFFF);
        send_request(8'hFF, 1'b1, 1'b1, 16'd1);
        // Start offset at the end of the haystack.
        send_request(8'h00, 1'b1, 1'b0, 16'd2);
        send_request(8'hFF, 1'b1, 1'b1, 16'd2);
        // Empty haystack with a real needle.
        send_request(8'h00, 1'b0, 1'b1, 16'd0);
        // Last request carries no byte.
        send_request(8'h00, 1'b1, 1'b0, 16'd0);
        send_request(8'hFF, 1'b1, 1'b0, 16'd0);
        send_request(8'h00, 1'b0, 1'b1, 16'd0);
        // Oversized length register saturates to a full sixteen-byte needle.
        set_needle(64'h8786_8584_8382_8180, 64'h8F8E_8D8C_8B8A_8988, 5'd31);
        haystack_text.delete();
        for (k = 0; k < NEEDLE_SLOTS; k++)
            haystack_text.push_back(needle_at(k));
        send_haystack(16'd0, 1'b0, 1'b0);
        // Needle longer than the haystack.
        haystack_text.delete();
        add_bytes(32'h0082_8180, 3);
        send_haystack(16'd0, 1'b0, 1'b0);
        // Single all-ones byte, start offset skips the first hit.
        set_needle('1, '0, 5'd1);
        haystack_text.delete();
        add_bytes(32'h00FF_FF00, 3);
        send_haystack(16'd2, 1'b0, 1'b0);
    endtask

    // Random needles, each followed by a batch of haystacks that often hold it.
    task automatic test_random_haystacks();
        int unsigned sent;
        int unsigned len;
        int unsigned n;
        int unsigned at;
        logic [15:0] start;
        sent = 0;
        while (sent < RANDOM_REQUESTS) begin
            idling = ($urandom_range(0, 3) != 0);
            set_needle(pick_word(), pick_word(), pick_length());
            n = active_length();
            repeat ($urandom_range(3, 10)) begin
                len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 24);
                haystack_text.delete();
                // Mostly needle bytes, so partial and full matches are common.
                repeat (len) begin
                    if (n > 0 && $urandom_range(0, 3) != 0)
                        haystack_text.push_back(needle_at($urandom_range(0, n - 1)));
                    else
                        haystack_text.push_back(8'($urandom));
                end
                if (n > 0 && len >= n && $urandom_range(0, 1) == 1) begin
                    at = $urandom_range(0, len - n);
                    for (int k = 0; k < n; k++)
                        haystack_text[at + k] = needle_at(k);
                end
                start = ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                                    : 16'($urandom_range(0, len + 2));
                send_haystack(start, $urandom_range(0, 2) == 0, $urandom_range(0, 7) == 0);
                sent += (len == 0) ? 1 : len;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        aresetn     <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_addr    <= REG_NEEDLE_LOW;
        cfg_wr_data <= '0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        s_tuser     <= '0;
        s_tlast     <= 1'b0;
        ndl_low  = '0;
        ndl_high = '0;
        ndl_len  = '0;
        clear_search();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_state();
        test_special_cases();
        test_random_haystacks();

        wait_idle();
        repeat (8) @(posedge aclk);
        $display("Run covered %0d requests, %0d search results, %0d needle settings.",
                 request_count, result_count, config_count);
        $display("Mismatches found: %0d", error_count);
        if (error_count == 0) begin
            $display("substring_first_match_unit verification clean");
        end else begin
            $display("substring_first_match_unit verification failed");
        end
        $finish;
    end

endmodule

### substring_first_match_unit.f
hdl/ssfm_pkg.sv
hdl/ssfm_cell.sv
hdl/ssfm_window.sv
hdl/substring_first_match_unit.sv
hdl/ssfm_checker.sv
verif/substring_first_match_unit_tb.sv
